/* hw/rtl/irac_pkg.sv */
// Shared types, remote command codes and display/amplifier helper functions
// for the IR remote audio controller. No dependencies.
package irac_pkg;

  // Remote codes acted on as raw codes
  localparam logic [31:0] CODE_REPEAT = 32'hFFFF_FFFF;
  localparam logic [31:0] CODE_MUTE_A = 32'd16460501;
  localparam logic [31:0] CODE_MUTE_B = 32'd2155807485;
  localparam logic [31:0] CODE_IN_SEL = 32'd16476311;

  // Segment patterns, bit0 = A .. bit6 = G
  localparam logic [6:0] SEG_DASH  = 7'h40;
  localparam logic [6:0] SEG_BLANK = 7'h00;
  localparam logic [6:0] SEG_LTR_A = 7'h77;
  localparam logic [6:0] SEG_LTR_U = 7'h3E;
  localparam logic [6:0] SEG_LTR_P = 7'h73;
  localparam logic [6:0] SEG_LTR_C = 7'h39;

  // Amplifier input byte values
  localparam logic [7:0] INB_MUTED = 8'hE0;
  localparam logic [7:0] INB_PC    = 8'h20;
  localparam logic [7:0] INB_AUX   = 8'h00;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_AUX,
    CMD_PC,
    CMD_VOL_UP,
    CMD_VOL_DN,
    CMD_BASS_UP,
    CMD_BASS_DN,
    CMD_TREB_UP,
    CMD_TREB_DN
  } cmd_t;

  typedef struct packed {
    logic [15:0] accept_gap;
    logic [15:0] revert_delay;
    logic [5:0]  vol_limit;
  } cfg_t;

  typedef struct packed {
    logic [6:0] digit_left;
    logic [6:0] digit_right;
    logic       frame_send;
    logic [7:0] vol_byte;
    logic [7:0] input_byte;
    logic [7:0] tone_byte;
  } result_t;

  // Held-code command decode
  function automatic cmd_t decode_cmd(logic [31:0] code);
    cmd_t c;
    case (code)
      32'd2155836045, 32'd83573445:  c = CMD_AUX;
      32'd2155851855, 32'd83606085:  c = CMD_PC;
      32'd2155813095, 32'd16486511:  c = CMD_VOL_UP;
      32'd2155809015, 32'd16490591:  c = CMD_VOL_DN;
      32'd2155815135, 32'd16494671:  c = CMD_BASS_UP;
      32'd2155831965, 32'd16462541:  c = CMD_BASS_DN;
      32'd2155811055, 32'd16484471:  c = CMD_TREB_UP;
      32'd2155827885, 32'd16452341:  c = CMD_TREB_DN;
      default:                       c = CMD_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] seg_font(logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h67;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Two-digit display of n in -9..99; returns {left, right}.
  // Tens digit via n*205 >> 11, exact for n < 100.
  function automatic logic [13:0] show_number(logic signed [7:0] n);
    logic [7:0]  neg;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  ones;
    logic [13:0] r;
    neg      = 8'(-n);
    prod     = 15'(n[6:0]) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'(tens) * 7'd10;
    ones     = 4'(n[6:0] - tens_x10);
    if (n < 0) begin
      r = {SEG_DASH, seg_font(neg[3:0])};
    end else if (n < 8'sd10) begin
      r = {SEG_BLANK, seg_font(n[3:0])};
    end else begin
      r = {seg_font(tens), seg_font(ones)};
    end
    return r;
  endfunction

  // 255 at zero, else 96 - ceil(8v/5) floored at 0; (8v+4)/5 via *205 >> 10
  function automatic logic [7:0] vol_to_byte(logic [5:0] v);
    logic [8:0]  x;
    logic [16:0] prod;
    logic [6:0]  q;
    logic [7:0]  b;
    x    = {v, 3'b000} + 9'd4;
    prod = 17'(x) * 17'd205;
    q    = prod[16:10];
    if (v == 6'd0) begin
      b = 8'hFF;
    end else if (q > 7'd96) begin
      b = 8'h00;
    end else begin
      b = 8'd96 - 8'(q);
    end
    return b;
  endfunction

  // Sign flag set for positive levels, magnitude in the low three bits
  function automatic logic [3:0] tone_nibble(logic signed [3:0] v);
    logic [3:0] mag;
    mag = v[3] ? 4'(-v) : v;
    return {(!v[3] && (v != 4'sd0)), mag[2:0]};
  endfunction

endpackage

/* hw/rtl/ir_remote_audio_controller.sv */
// IR remote audio controller: top level with input and result registers.
// Depends on irac_pkg, irac_cfg and irac_core.
//
// Usage:
// - Input channel (in_valid/in_ready, in_op, in_ir_code): each transfer is a
//   decoded remote code (in_op = 0) or a one-millisecond tick (in_op = 1).
// - Result channel (out_valid/out_ready): exactly one result per input
//   transfer, in order: both 7-segment digits, frame_send and the current
//   amplifier bytes (volume, input/mute, tone).
// - Config port (APB-style, pready tied high): accept_gap at 0x0,
//   revert_delay at 0x4, volume limit at 0x8. Write only while idle.
// - Path: an accepted item goes into the input register, then into the
//   result register once the result slot is free, and is offered from there.
// - Throughput: one transfer per cycle while out_ready is high; the whole
//   update is one pass of logic between the input and result registers.
// - Stall: when out_ready is low the result register holds; the input
//   register still takes one more item, then in_ready drops until the
//   result is taken.
// - Reset (rst_n low, synchronous): muted, aux input, volume 20, flat tone,
//   dashes on the display, both channels empty, registers to defaults.
module ir_remote_audio_controller import irac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_ir_code,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_digit_left,
  output logic [6:0]  out_digit_right,
  output logic        out_frame_send,
  output logic [7:0]  out_vol_byte,
  output logic [7:0]  out_input_byte,
  output logic [7:0]  out_tone_byte,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  result_t     res_nxt;
  result_t     res_r;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_op_r;
  logic [31:0] s1_code_r;
  logic        out_valid_r, out_valid_nxt;
  logic        in_xfer;
  logic        step_en;

  // item in the input register moves on whenever the result slot frees up
  assign step_en  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step_en;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (step_en) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r   <= in_op;
      s1_code_r <= in_ir_code;
    end
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  irac_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irac_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .op      (s1_op_r),
    .ir_code (s1_code_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  assign out_valid       = out_valid_r;
  assign out_digit_left  = res_r.digit_left;
  assign out_digit_right = res_r.digit_right;
  assign out_frame_send  = res_r.frame_send;
  assign out_vol_byte    = res_r.vol_byte;
  assign out_input_byte  = res_r.input_byte;
  assign out_tone_byte   = res_r.tone_byte;

endmodule

/* hw/rtl/irac_cfg.sv */
// APB-style configuration registers of the IR remote audio controller.
// Depends on irac_pkg (cfg_t).
module irac_cfg import irac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  localparam logic [1:0] REG_ACCEPT_GAP   = 2'd0;
  localparam logic [1:0] REG_REVERT_DELAY = 2'd1;
  localparam logic [1:0] REG_VOL_LIMIT    = 2'd2;

  logic [15:0] accept_gap_r, accept_gap_nxt;
  logic [15:0] revert_delay_r, revert_delay_nxt;
  logic [5:0]  vol_limit_r, vol_limit_nxt;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    accept_gap_nxt   = accept_gap_r;
    revert_delay_nxt = revert_delay_r;
    vol_limit_nxt    = vol_limit_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ACCEPT_GAP:   accept_gap_nxt   = pwdata[15:0];
        REG_REVERT_DELAY: revert_delay_nxt = pwdata[15:0];
        REG_VOL_LIMIT:    vol_limit_nxt    = pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACCEPT_GAP:   prdata = 32'(accept_gap_r);
      REG_REVERT_DELAY: prdata = 32'(revert_delay_r);
      REG_VOL_LIMIT:    prdata = 32'(vol_limit_r);
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_gap_r   <= 16'd200;
      revert_delay_r <= 16'd2000;
      vol_limit_r    <= 6'd60;
    end else begin
      accept_gap_r   <= accept_gap_nxt;
      revert_delay_r <= revert_delay_nxt;
      vol_limit_r    <= vol_limit_nxt;
    end
  end

  assign cfg.accept_gap   = accept_gap_r;
  assign cfg.revert_delay = revert_delay_r;
  assign cfg.vol_limit    = vol_limit_r;

endmodule

/* hw/rtl/irac_core.sv */
// Controller state and the single-pass update for one code or tick item.
// Depends on irac_pkg (cfg_t, result_t, command decode, display helpers).
module irac_core import irac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic        op,
  input  logic [31:0] ir_code,
  input  cfg_t        cfg,
  output result_t     res_nxt
);

  logic              muted_r, muted_nxt;
  logic              input_is_pc_r, input_is_pc_nxt;
  logic [5:0]        volume_r, volume_nxt;
  logic signed [3:0] bass_r, bass_nxt;
  logic signed [3:0] treble_r, treble_nxt;
  logic [31:0]       held_code_r, held_code_nxt;
  logic [6:0]        left_seg_r, left_seg_nxt;
  logic [6:0]        right_seg_r, right_seg_nxt;
  logic [15:0]       gap_cnt_r, gap_cnt_nxt;
  logic [15:0]       revert_cnt_r, revert_cnt_nxt;
  logic              revert_armed_r, revert_armed_nxt;

  logic        acted;
  logic        raw_mute;
  logic [6:0]  vol_inc;
  logic [5:0]  vol_dec;
  cmd_t        cmd;

  assign raw_mute = (ir_code == CODE_MUTE_A) || (ir_code == CODE_MUTE_B);
  assign vol_inc  = 7'(volume_r) + 7'd1;
  assign vol_dec  = volume_r - 6'd1;

  always_comb begin
    muted_nxt        = muted_r;
    input_is_pc_nxt  = input_is_pc_r;
    volume_nxt       = volume_r;
    bass_nxt         = bass_r;
    treble_nxt       = treble_r;
    held_code_nxt    = held_code_r;
    left_seg_nxt     = left_seg_r;
    right_seg_nxt    = right_seg_r;
    gap_cnt_nxt      = gap_cnt_r;
    revert_cnt_nxt   = revert_cnt_r;
    revert_armed_nxt = revert_armed_r;
    acted            = 1'b0;

    if (ir_code != CODE_REPEAT) begin
      cmd = decode_cmd(ir_code);
    end else begin
      cmd = decode_cmd(held_code_r);
    end

    if (step_en) begin
      if (!op) begin
        if (ir_code != CODE_REPEAT) held_code_nxt = ir_code;
        if (gap_cnt_r >= cfg.accept_gap) begin
          acted            = 1'b1;
          gap_cnt_nxt      = 16'd0;
          revert_cnt_nxt   = 16'd0;
          revert_armed_nxt = 1'b1;
          // while muted only the mute codes get through
          priority if (muted_r && !raw_mute) begin
          end else if (ir_code == CODE_IN_SEL) begin
            input_is_pc_nxt = !input_is_pc_r;
            {left_seg_nxt, right_seg_nxt} = input_is_pc_r ? {SEG_LTR_A, SEG_LTR_U}
                                                          : {SEG_LTR_P, SEG_LTR_C};
          end else if (raw_mute) begin
            muted_nxt = !muted_r;
            if (!muted_r) begin
              {left_seg_nxt, right_seg_nxt} = {SEG_DASH, SEG_DASH};
            end else begin
              {left_seg_nxt, right_seg_nxt} = show_number(8'(volume_r));
            end
          end else begin
            unique case (cmd)
              CMD_AUX: begin
                input_is_pc_nxt = 1'b0;
                {left_seg_nxt, right_seg_nxt} = {SEG_LTR_A, SEG_LTR_U};
              end
              CMD_PC: begin
                input_is_pc_nxt = 1'b1;
                {left_seg_nxt, right_seg_nxt} = {SEG_LTR_P, SEG_LTR_C};
              end
              CMD_VOL_UP: begin
                volume_nxt = (vol_inc > 7'(cfg.vol_limit)) ? cfg.vol_limit : vol_inc[5:0];
                {left_seg_nxt, right_seg_nxt} = show_number(8'(volume_nxt));
              end
              CMD_VOL_DN: begin
                priority if (volume_r == 6'd0) begin
                  volume_nxt = 6'd0;
                end else if (vol_dec > cfg.vol_limit) begin
                  volume_nxt = cfg.vol_limit;
                end else begin
                  volume_nxt = vol_dec;
                end
                {left_seg_nxt, right_seg_nxt} = show_number(8'(volume_nxt));
              end
              CMD_BASS_UP: begin
                bass_nxt = (bass_r >= 4'sd7) ? 4'sd7 : bass_r + 4'sd1;
                {left_seg_nxt, right_seg_nxt} = show_number(8'(bass_nxt));
              end
              CMD_BASS_DN: begin
                bass_nxt = (bass_r <= -4'sd7) ? -4'sd7 : bass_r - 4'sd1;
                {left_seg_nxt, right_seg_nxt} = show_number(8'(bass_nxt));
              end
              CMD_TREB_UP: begin
                treble_nxt = (treble_r >= 4'sd7) ? 4'sd7 : treble_r + 4'sd1;
                {left_seg_nxt, right_seg_nxt} = show_number(8'(treble_nxt));
              end
              CMD_TREB_DN: begin
                treble_nxt = (treble_r <= -4'sd7) ? -4'sd7 : treble_r - 4'sd1;
                {left_seg_nxt, right_seg_nxt} = show_number(8'(treble_nxt));
              end
              default: ;
            endcase
          end
        end
      end else begin
        if (gap_cnt_r != CNT_MAX) gap_cnt_nxt = gap_cnt_r + 16'd1;
        if (revert_armed_r && (revert_cnt_r != CNT_MAX)) begin
          revert_cnt_nxt = revert_cnt_r + 16'd1;
        end
      end

      // display falls back to volume once the revert delay has run out, unless muted
      if (revert_armed_nxt && (revert_cnt_nxt >= cfg.revert_delay)) begin
        revert_armed_nxt = 1'b0;
        if (!muted_nxt) {left_seg_nxt, right_seg_nxt} = show_number(8'(volume_nxt));
      end
    end
  end

  always_comb begin
    res_nxt.digit_left  = left_seg_nxt;
    res_nxt.digit_right = right_seg_nxt;
    res_nxt.frame_send  = acted;
    res_nxt.vol_byte    = vol_to_byte(volume_nxt);
    res_nxt.input_byte  = muted_nxt ? INB_MUTED : (input_is_pc_nxt ? INB_PC : INB_AUX);
    res_nxt.tone_byte   = {tone_nibble(bass_nxt), tone_nibble(treble_nxt)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      muted_r        <= 1'b1;
      input_is_pc_r  <= 1'b0;
      volume_r       <= 6'd20;
      bass_r         <= 4'sd0;
      treble_r       <= 4'sd0;
      held_code_r    <= 32'd0;
      left_seg_r     <= SEG_DASH;
      right_seg_r    <= SEG_DASH;
      gap_cnt_r      <= 16'd0;
      revert_cnt_r   <= 16'd0;
      revert_armed_r <= 1'b1;
    end else begin
      muted_r        <= muted_nxt;
      input_is_pc_r  <= input_is_pc_nxt;
      volume_r       <= volume_nxt;
      bass_r         <= bass_nxt;
      treble_r       <= treble_nxt;
      held_code_r    <= held_code_nxt;
      left_seg_r     <= left_seg_nxt;
      right_seg_r    <= right_seg_nxt;
      gap_cnt_r      <= gap_cnt_nxt;
      revert_cnt_r   <= revert_cnt_nxt;
      revert_armed_r <= revert_armed_nxt;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ir_remote_audio_controller: directed and random remote
// codes and ticks, checked against a cycle-free model of the controller state.
// Depends on irac_pkg and the ir_remote_audio_controller RTL.
module tb_top;
  import irac_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DUT_LATENCY  = 4;      // input reg + result reg, plus margin
  localparam int REPORT_MAX   = 10;
  localparam int KEY_COUNT    = 19;     // 16 held-code keys, input select, 2 mutes
  localparam int COUNT_SAT    = 65535;

  // Held-code command keys, two remotes per command
  localparam logic [31:0] KEY_AUX_A     = 32'd2155836045;
  localparam logic [31:0] KEY_AUX_B     = 32'd83573445;
  localparam logic [31:0] KEY_PC_A      = 32'd2155851855;
  localparam logic [31:0] KEY_PC_B      = 32'd83606085;
  localparam logic [31:0] KEY_VOL_UP_A  = 32'd2155813095;
  localparam logic [31:0] KEY_VOL_UP_B  = 32'd16486511;
  localparam logic [31:0] KEY_VOL_DN_A  = 32'd2155809015;
  localparam logic [31:0] KEY_VOL_DN_B  = 32'd16490591;
  localparam logic [31:0] KEY_BASS_UP_A = 32'd2155815135;
  localparam logic [31:0] KEY_BASS_UP_B = 32'd16494671;
  localparam logic [31:0] KEY_BASS_DN_A = 32'd2155831965;
  localparam logic [31:0] KEY_BASS_DN_B = 32'd16462541;
  localparam logic [31:0] KEY_TREB_UP_A = 32'd2155811055;
  localparam logic [31:0] KEY_TREB_UP_B = 32'd16484471;
  localparam logic [31:0] KEY_TREB_DN_A = 32'd2155827885;
  localparam logic [31:0] KEY_TREB_DN_B = 32'd16452341;

  typedef enum logic {OP_CODE = 1'b0, OP_TICK = 1'b1} op_t;
  typedef enum logic [1:0] {REG_ACCEPT_GAP, REG_REVERT_DELAY, REG_VOL_LIMIT} cfg_reg_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_MOSTLY} rx_pattern_t;

  // DUT connections, all inputs known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        in_op      = 1'b0;
  logic [31:0] in_ir_code = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [6:0]  out_digit_left;
  logic [6:0]  out_digit_right;
  logic        out_frame_send;
  logic [7:0]  out_vol_byte;
  logic [7:0]  out_input_byte;
  logic [7:0]  out_tone_byte;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [3:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  ir_remote_audio_controller i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_ir_code     (in_ir_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_left (out_digit_left),
    .out_digit_right(out_digit_right),
    .out_frame_send (out_frame_send),
    .out_vol_byte   (out_vol_byte),
    .out_input_byte (out_input_byte),
    .out_tone_byte  (out_tone_byte),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Controller model: shadow registers and state, updated once per accepted
  // transfer. Every transfer produces exactly one panel snapshot.
  // ---------------------------------------------------------------------------
  int          gap_min;         // accept_gap
  int          revert_ticks;    // revert_delay
  int          vol_ceiling;     // volume limit

  bit          muted_st;
  bit          pc_selected;
  int          vol_lvl;
  int          bass_lvl;
  int          treb_lvl;
  logic [31:0] held_key;
  logic [6:0]  seg_left;
  logic [6:0]  seg_right;
  int          gap_ticks;
  int          revert_count;
  bit          revert_armed;

  result_t     queued_panels[$];   // expected snapshots, oldest first

  function automatic void reset_controller_model();
    gap_min      = 200;
    revert_ticks = 2000;
    vol_ceiling  = 60;
    muted_st     = 1'b1;
    pc_selected  = 1'b0;
    vol_lvl      = 20;
    bass_lvl     = 0;
    treb_lvl     = 0;
    held_key     = '0;
    seg_left     = SEG_DASH;
    seg_right    = SEG_DASH;
    gap_ticks    = 0;
    revert_count = 0;
    revert_armed = 1'b1;
  endfunction

  function automatic logic [6:0] digit_glyph(int d);
    case (d)
      0:       return 7'h3F;
      1:       return 7'h06;
      2:       return 7'h5B;
      3:       return 7'h4F;
      4:       return 7'h66;
      5:       return 7'h6D;
      6:       return 7'h7D;
      7:       return 7'h07;
      8:       return 7'h7F;
      default: return 7'h67;
    endcase
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Negative values get a dash on the left, single digits a blank
  function automatic void display_value(int n);
    int m;
    m = clip(n, -9, 99);
    if (m < 0) begin
      seg_left  = SEG_DASH;
      seg_right = digit_glyph(-m);
    end else if (m < 10) begin
      seg_left  = SEG_BLANK;
      seg_right = digit_glyph(m);
    end else begin
      seg_left  = digit_glyph(m / 10);
      seg_right = digit_glyph(m % 10);
    end
  endfunction

  function automatic void choose_input(bit pc);
    pc_selected = pc;
    seg_left    = pc ? SEG_LTR_P : SEG_LTR_A;
    seg_right   = pc ? SEG_LTR_C : SEG_LTR_U;
  endfunction

  function automatic cmd_t held_command(logic [31:0] key);
    case (key)
      KEY_AUX_A, KEY_AUX_B:         return CMD_AUX;
      KEY_PC_A, KEY_PC_B:           return CMD_PC;
      KEY_VOL_UP_A, KEY_VOL_UP_B:   return CMD_VOL_UP;
      KEY_VOL_DN_A, KEY_VOL_DN_B:   return CMD_VOL_DN;
      KEY_BASS_UP_A, KEY_BASS_UP_B: return CMD_BASS_UP;
      KEY_BASS_DN_A, KEY_BASS_DN_B: return CMD_BASS_DN;
      KEY_TREB_UP_A, KEY_TREB_UP_B: return CMD_TREB_UP;
      KEY_TREB_DN_A, KEY_TREB_DN_B: return CMD_TREB_DN;
      default:                      return CMD_NONE;
    endcase
  endfunction

  // Mute and input select look at the raw code, the rest at the held one
  function automatic void act_on_key(logic [31:0] raw);
    bit is_mute;
    is_mute = (raw == CODE_MUTE_A) || (raw == CODE_MUTE_B);
    if (muted_st && !is_mute) return;
    if (raw == CODE_IN_SEL) begin
      choose_input(!pc_selected);
      return;
    end
    if (is_mute) begin
      muted_st = !muted_st;
      if (muted_st) begin
        seg_left  = SEG_DASH;
        seg_right = SEG_DASH;
      end else begin
        display_value(vol_lvl);
      end
      return;
    end
    case (held_command(held_key))
      CMD_AUX:     choose_input(1'b0);
      CMD_PC:      choose_input(1'b1);
      CMD_VOL_UP: begin
        vol_lvl = clip(vol_lvl + 1, 0, vol_ceiling);
        display_value(vol_lvl);
      end
      CMD_VOL_DN: begin
        vol_lvl = clip(vol_lvl - 1, 0, vol_ceiling);
        display_value(vol_lvl);
      end
      CMD_BASS_UP: begin
        bass_lvl = clip(bass_lvl + 1, -7, 7);
        display_value(bass_lvl);
      end
      CMD_BASS_DN: begin
        bass_lvl = clip(bass_lvl - 1, -7, 7);
        display_value(bass_lvl);
      end
      CMD_TREB_UP: begin
        treb_lvl = clip(treb_lvl + 1, -7, 7);
        display_value(treb_lvl);
      end
      CMD_TREB_DN: begin
        treb_lvl = clip(treb_lvl - 1, -7, 7);
        display_value(treb_lvl);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [3:0] tone_field(int lvl);
    int mag;
    mag = (lvl < 0) ? -lvl : lvl;
    return {lvl > 0, 3'(mag)};
  endfunction

  function automatic result_t next_panel(op_t op, logic [31:0] code);
    result_t r;
    bit      acted;
    int      att;
    acted = 1'b0;
    if (op == OP_CODE) begin
      if (code != CODE_REPEAT) held_key = code;
      if (gap_ticks >= gap_min) begin
        act_on_key(code);
        gap_ticks    = 0;
        revert_count = 0;
        revert_armed = 1'b1;
        acted        = 1'b1;
      end
    end else begin
      if (gap_ticks < COUNT_SAT) gap_ticks++;
      if (revert_armed && revert_count < COUNT_SAT) revert_count++;
    end
    // display falls back to the volume; a revert while muted is just spent
    if (revert_armed && revert_count >= revert_ticks) begin
      revert_armed = 1'b0;
      if (!muted_st) display_value(vol_lvl);
    end
    r.digit_left  = seg_left;
    r.digit_right = seg_right;
    r.frame_send  = acted;
    if (vol_lvl <= 0) begin
      r.vol_byte = 8'hFF;
    end else begin
      att        = 96 - (8 * vol_lvl + 4) / 5;
      r.vol_byte = (att < 0) ? 8'h00 : 8'(att);
    end
    r.input_byte = muted_st ? INB_MUTED : (pc_selected ? INB_PC : INB_AUX);
    r.tone_byte  = {tone_field(bass_lvl), tone_field(treb_lvl)};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall patterns plus a long hold-off on request, and the
  // checker on every result transfer.
  // ---------------------------------------------------------------------------
  rx_pattern_t rx_mode     = RX_OPEN;
  int          rx_tick     = 0;
  int          rx_hold     = 0;   // cycles the receiver still refuses results
  int          error_count = 0;
  int          result_idx  = 0;
  int          cycle_count = 0;

  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick >= 40) begin
      rx_tick = 0;
      rx_mode = rx_pattern_t'($urandom_range(0, 3));
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_EVERY4: out_ready <= (rx_tick % 4 == 0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (queued_panels.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("result %0d: arrived with nothing pending", result_idx);
      end else begin
        want = queued_panels.pop_front();
        if (out_digit_left !== want.digit_left || out_digit_right !== want.digit_right ||
            out_frame_send !== want.frame_send || out_vol_byte !== want.vol_byte ||
            out_input_byte !== want.input_byte || out_tone_byte !== want.tone_byte) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("result %0d: expected L=%h R=%h frame=%b vol=%h in=%h tone=%h",
                     result_idx, want.digit_left, want.digit_right, want.frame_send,
                     want.vol_byte, want.input_byte, want.tone_byte);
            $display("result %0d: actual   L=%h R=%h frame=%b vol=%h in=%h tone=%h",
                     result_idx, out_digit_left, out_digit_right, out_frame_send,
                     out_vol_byte, out_input_byte, out_tone_byte);
          end
        end
      end
      result_idx++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               queued_panels.size());
      $display("ir_remote_audio_controller: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts with random gaps. All tasks start and end on a falling edge.
  // ---------------------------------------------------------------------------
  bit tx_bursty  = 1'b1;
  int burst_left = 0;
  int items_sent = 0;

  task automatic send_item(input op_t op, input logic [31:0] code);
    int idle;
    if (tx_bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      idle       = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid   <= 1'b1;
    in_op      <= op;
    in_ir_code <= code;
    do @(posedge clk); while (!in_ready);
    queued_panels.push_back(next_panel(op, code));
    items_sent++;
    @(negedge clk);
  endtask

  // Tick payload is don't-care, so it carries random bits
  task automatic send_ticks(input int n);
    repeat (n) send_item(OP_TICK, $urandom());
  endtask

  // Sender stops until every expected result has arrived, then lets the
  // pipeline settle
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(negedge clk); while (queued_panels.size() != 0);
    repeat (DUT_LATENCY) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ACCEPT_GAP:   gap_min      = int'(value[15:0]);
      REG_REVERT_DELAY: revert_ticks = int'(value[15:0]);
      default:          vol_ceiling  = int'(value[5:0]);
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_all(input int gap, input int revert, input int vmax);
    cfg_write(REG_ACCEPT_GAP, gap);
    cfg_write(REG_REVERT_DELAY, revert);
    cfg_write(REG_VOL_LIMIT, vmax);
  endtask

  function automatic logic [31:0] remote_key(int idx);
    case (idx)
      0:       return KEY_AUX_A;
      1:       return KEY_AUX_B;
      2:       return KEY_PC_A;
      3:       return KEY_PC_B;
      4:       return KEY_VOL_UP_A;
      5:       return KEY_VOL_UP_B;
      6:       return KEY_VOL_DN_A;
      7:       return KEY_VOL_DN_B;
      8:       return KEY_BASS_UP_A;
      9:       return KEY_BASS_UP_B;
      10:      return KEY_BASS_DN_A;
      11:      return KEY_BASS_DN_B;
      12:      return KEY_TREB_UP_A;
      13:      return KEY_TREB_UP_B;
      14:      return KEY_TREB_DN_A;
      15:      return KEY_TREB_DN_B;
      16:      return CODE_IN_SEL;
      17:      return CODE_MUTE_A;
      default: return CODE_MUTE_B;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers: accept_gap 200 keeps every early code from acting.
  // A repeat before any code leaves the held code empty.
  task automatic test_reset_defaults();
    send_item(OP_CODE, CODE_REPEAT);
    send_item(OP_TICK, '1);
    send_item(OP_CODE, KEY_VOL_UP_A);
    wait_results_done();
  endtask

  // Muted: other codes still act (frame sent) but change nothing.
  // Revert fires while muted and leaves the dashes.
  task automatic test_mute_gate();
    cfg_all(0, 2, 60);
    send_item(OP_CODE, KEY_VOL_UP_A);
    send_item(OP_CODE, CODE_IN_SEL);
    send_item(OP_CODE, CODE_MUTE_A);
    send_item(OP_CODE, CODE_MUTE_B);
    send_ticks(3);
    send_item(OP_CODE, CODE_MUTE_A);
  endtask

  // One of each command, a repeat re-applying the held one, an unknown code
  task automatic test_commands();
    send_item(OP_CODE, KEY_AUX_A);
    send_item(OP_CODE, KEY_PC_B);
    send_item(OP_CODE, KEY_VOL_UP_B);
    send_item(OP_CODE, KEY_VOL_DN_A);
    send_item(OP_CODE, KEY_BASS_UP_B);
    send_item(OP_CODE, KEY_BASS_DN_A);
    send_item(OP_CODE, KEY_TREB_UP_A);
    send_item(OP_CODE, KEY_TREB_DN_B);
    send_item(OP_CODE, CODE_REPEAT);
    send_item(OP_CODE, CODE_IN_SEL);
    send_item(OP_CODE, 32'h1234_5678);
    wait_results_done();
  endtask

  // Volume above the ceiling clamps on the next command; zero gives 0xFF
  task automatic test_volume_clamp();
    cfg_write(REG_VOL_LIMIT, 0);
    send_item(OP_CODE, KEY_VOL_UP_A);
    send_item(OP_CODE, KEY_VOL_DN_B);
    wait_results_done();
  endtask

  // revert_delay 0: display returns to volume in the same transfer
  task automatic test_zero_revert();
    cfg_all(0, 0, 60);
    send_item(OP_CODE, KEY_BASS_UP_A);
    send_item(OP_CODE, KEY_VOL_UP_B);
    wait_results_done();
  endtask

  // Long receiver hold-off while the sender keeps offering at full rate,
  // so the block fills and drops in_ready
  task automatic test_backpressure();
    tx_bursty = 1'b0;
    rx_hold   = 120;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_item(OP_CODE, remote_key($urandom_range(0, KEY_COUNT - 1)));
      else send_item(OP_TICK, $urandom());
    end
    tx_bursty = 1'b1;
    wait_results_done();
  endtask

  // Well-formed remote traffic: a key, optional repeats, ticks in between,
  // mixed with noise codes and premature presses
  task automatic test_random_traffic();
    int start_items;
    int kind;
    int reps;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       cfg_all(0, 0, 60);
        1:       cfg_all(1, 4, 60);
        2:       cfg_all(2, 65535, 9);
        3:       cfg_all(0, 1, 1);
        4:       cfg_all($urandom_range(0, 3), $urandom_range(0, 20), $urandom_range(0, 60));
        default: cfg_all(3, 10, 60);
      endcase
      start_items = items_sent;
      while (items_sent - start_items < 90) begin
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
          send_ticks($urandom_range(0, gap_min + 1));
          // steer out of mute so most commands land
          if (muted_st && $urandom_range(0, 9) < 6)
            send_item(OP_CODE, remote_key($urandom_range(17, 18)));
          else
            send_item(OP_CODE, remote_key($urandom_range(0, KEY_COUNT - 1)));
          reps = $urandom_range(0, 10);
          repeat (reps) begin
            send_ticks($urandom_range(0, gap_min));
            send_item(OP_CODE, CODE_REPEAT);
          end
        end else if (kind < 75) begin
          send_ticks($urandom_range(1, 12));
        end else if (kind < 90) begin
          send_item(OP_CODE, $urandom());
        end else begin
          send_item(OP_CODE, CODE_REPEAT);
        end
      end
      wait_results_done();
    end
  endtask

  // Largest gap and revert settings: short traffic never reaches either
  task automatic test_long_delays();
    cfg_all(65535, 65535, 60);
    tx_bursty = 1'b0;
    send_item(OP_CODE, KEY_VOL_UP_B);
    send_ticks(6);
    send_item(OP_CODE, CODE_REPEAT);
    send_item(OP_TICK, '0);
    send_item(OP_CODE, KEY_VOL_DN_A);
    tx_bursty = 1'b1;
    wait_results_done();
  endtask

  initial begin
    reset_controller_model();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_mute_gate();
    test_commands();
    test_volume_clamp();
    test_zero_revert();
    test_backpressure();
    test_random_traffic();
    test_long_delays();

    wait_results_done();
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("ir_remote_audio_controller: match");
    end else begin
      $display("ir_remote_audio_controller: mismatch");
    end
    $finish;
  end

endmodule
